[hw/rtl/billboard_quad_expander_macros.svh]
// ----------------------------------------------------------------------------
// Billboard quad expander assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BILLBOARD_QUAD_EXPANDER_MACROS_SVH
`define BILLBOARD_QUAD_EXPANDER_MACROS_SVH
`ifndef SYNTHESIS
`define BQE_ASSERT_IMPLIES(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("bqe: assertion failed");
`define BQE_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("bqe: assertion failed");
`else
`define BQE_ASSERT_IMPLIES(label, ck, rn, ante, cons)
`define BQE_ASSERT_NEXT(label, ck, rn, ante, cons)
`endif
`endif

[hw/rtl/bqe_pkg.sv]
// ----------------------------------------------------------------------------
// bqe_pkg
// Types, widths and helpers shared by the billboard quad expander.
// ----------------------------------------------------------------------------
`default_nettype none

package bqe_pkg;

    localparam int POS_W    = 20;
    localparam int ALPHA_W  = 8;
    localparam int SIZE_W   = 16;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 16'd197;

    // normaliser datapath
    localparam int WIDE_W   = 31;
    localparam int UNIT_W   = 16;
    localparam int MAG_W    = 30;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int SUM_W    = SQ_W + 2;
    localparam int ROOT_W   = SUM_W / 2;
    localparam int REM_W    = ROOT_W + 3;
    localparam int FRAC_W   = 14;
    localparam int DIVN_W   = MAG_W + FRAC_W + 1;
    localparam int Q_W      = FRAC_W + 1;
    localparam int SH_W     = 5;

    // corner offset scaling
    localparam int PROD_W   = Q_W + SIZE_W;
    localparam int SCALE_W  = PROD_W + 2;
    localparam int ROUND_SH = 15;
    localparam int OFF_W    = SCALE_W - ROUND_SH + 1;

    localparam int CORNER_W = 2;
    localparam logic [CORNER_W-1:0] LAST_CORNER = 2'd3;
    // per-corner bits, indexed by corner number
    localparam logic [3:0] CORNER_USE_W = 4'b0101;
    localparam logic [3:0] CORNER_NEG   = 4'b1001;
    localparam logic [3:0] CORNER_TEX_U = 4'b1100;
    localparam logic [3:0] CORNER_TEX_V = 4'b1001;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [ALPHA_W-1:0]      alpha;
    } star_t;

    typedef struct packed {
        logic signed [UNIT_W-1:0] x;
        logic signed [UNIT_W-1:0] y;
        logic signed [UNIT_W-1:0] z;
    } unit_vec_t;

    typedef struct packed {
        logic signed [WIDE_W-1:0] x;
        logic signed [WIDE_W-1:0] y;
        logic signed [WIDE_W-1:0] z;
    } wide_vec_t;

    typedef struct packed {
        star_t     star;
        logic      degen;
        unit_vec_t vec;
    } tag_t;

    localparam int STAR_W = $bits(star_t);
    localparam int TAG_W  = $bits(tag_t);

    // shift that brings the top set bit to the MSB
    function automatic logic [SH_W-1:0] lead_zeros(input logic [MAG_W-1:0] v);
        logic [SH_W-1:0] n;
        n = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (v[i])
            begin
                n = SH_W'(MAG_W - 1 - i);
            end
        end
        return n;
    endfunction

    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_W:0] v);
        logic signed [POS_W-1:0] r;
        if (v[POS_W] != v[POS_W-1])
        begin
            r = v[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end
        else
        begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/bqe_if.sv]
// ----------------------------------------------------------------------------
// bqe interfaces
// Star input, vertex output and size configuration channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface bqe_star_if;
    logic                              valid;
    logic                              ready;
    logic signed [bqe_pkg::POS_W-1:0]  pos_x;
    logic signed [bqe_pkg::POS_W-1:0]  pos_y;
    logic signed [bqe_pkg::POS_W-1:0]  pos_z;
    logic [bqe_pkg::ALPHA_W-1:0]       alpha_byte;

    modport source (output valid, pos_x, pos_y, pos_z, alpha_byte, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, alpha_byte, output ready);
endinterface

interface bqe_vert_if;
    logic                              valid;
    logic                              ready;
    logic signed [bqe_pkg::POS_W-1:0]  vert_x;
    logic signed [bqe_pkg::POS_W-1:0]  vert_y;
    logic signed [bqe_pkg::POS_W-1:0]  vert_z;
    logic                              tex_u;
    logic                              tex_v;
    logic [bqe_pkg::ALPHA_W-1:0]       vert_alpha;
    logic                              degenerate;
    logic                              last_corner;

    modport source (output valid, vert_x, vert_y, vert_z, tex_u, tex_v, vert_alpha,
                    degenerate, last_corner, input ready);
    modport sink   (input valid, vert_x, vert_y, vert_z, tex_u, tex_v, vert_alpha,
                    degenerate, last_corner, output ready);
endinterface

interface bqe_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bqe_pkg::SIZE_W-1:0]     star_size;

    modport source (output valid, star_size, input ready);
    modport sink   (input valid, star_size, output ready);
endinterface

`default_nettype wire

[hw/rtl/bqe_norm3.sv]
// ----------------------------------------------------------------------------
// bqe_norm3
// Pipelined 3-vector normaliser to Q1.14: scale, sum of squares, bit-serial
// square root one step a stage, then three restoring dividers.
// ----------------------------------------------------------------------------
`default_nettype none

module bqe_norm3 #(
    parameter int SIDE_W = bqe_pkg::TAG_W
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                adv,
    input  wire logic                in_vld,
    input  wire bqe_pkg::wide_vec_t  in_vec,
    input  wire logic [SIDE_W-1:0]   in_side,
    output logic                     out_vld,
    output bqe_pkg::unit_vec_t       out_vec,
    output logic [SIDE_W-1:0]        out_side
);
    import bqe_pkg::*;

    typedef struct packed {
        logic [2:0]        neg;
        logic              zero;
        logic [SIDE_W-1:0] side;
    } ctl_t;

    typedef logic [2:0][MAG_W-1:0] mag3_t;

    // ---- stage 1: magnitudes
    logic signed [WIDE_W-1:0] comp [3];
    mag3_t mag_s1_next;
    ctl_t  ctl_s1_next;
    logic  vld_s1_reg;
    mag3_t mag_s1_reg;
    ctl_t  ctl_s1_reg;

    assign comp[0] = in_vec.x;
    assign comp[1] = in_vec.y;
    assign comp[2] = in_vec.z;

    always_comb
    begin
        ctl_s1_next.side = in_side;
        ctl_s1_next.zero = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            ctl_s1_next.neg[i] = comp[i][WIDE_W-1];
            mag_s1_next[i] = comp[i][WIDE_W-1] ? MAG_W'(-comp[i]) : MAG_W'(comp[i]);
        end
    end

    // ---- stage 2: largest magnitude and its shift
    logic [MAG_W-1:0] max01;
    logic [MAG_W-1:0] max_all;
    logic             vld_s2_reg;
    mag3_t            mag_s2_reg;
    ctl_t             ctl_s2_reg;
    logic [SH_W-1:0]  sh_s2_reg;

    assign max01   = (mag_s1_reg[0] > mag_s1_reg[1]) ? mag_s1_reg[0] : mag_s1_reg[1];
    assign max_all = (max01 > mag_s1_reg[2]) ? max01 : mag_s1_reg[2];

    // ---- stage 3: scale, stage 4: squares, stage 5: sum
    logic                vld_s3_reg;
    mag3_t               mag_s3_reg;
    ctl_t                ctl_s3_reg;
    logic                vld_s4_reg;
    mag3_t               mag_s4_reg;
    ctl_t                ctl_s4_reg;
    logic [2:0][SQ_W-1:0] sq_s4_reg;
    logic                vld_s5_reg;
    mag3_t               mag_s5_reg;
    ctl_t                ctl_s5_reg;
    logic [SUM_W-1:0]    sum_s5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_s1_reg <= 1'b0;
            vld_s2_reg <= 1'b0;
            vld_s3_reg <= 1'b0;
            vld_s4_reg <= 1'b0;
            vld_s5_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_s1_reg <= in_vld;
            vld_s2_reg <= vld_s1_reg;
            vld_s3_reg <= vld_s2_reg;
            vld_s4_reg <= vld_s3_reg;
            vld_s5_reg <= vld_s4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_s1_reg      <= mag_s1_next;
            ctl_s1_reg      <= ctl_s1_next;
            mag_s2_reg      <= mag_s1_reg;
            ctl_s2_reg.neg  <= ctl_s1_reg.neg;
            ctl_s2_reg.side <= ctl_s1_reg.side;
            ctl_s2_reg.zero <= (max_all == '0);
            sh_s2_reg       <= lead_zeros(max_all);
            for (int i = 0; i < 3; i++)
            begin
                mag_s3_reg[i] <= mag_s2_reg[i] << sh_s2_reg;
                sq_s4_reg[i]  <= SQ_W'(mag_s3_reg[i]) * SQ_W'(mag_s3_reg[i]);
            end
            ctl_s3_reg <= ctl_s2_reg;
            mag_s4_reg <= mag_s3_reg;
            ctl_s4_reg <= ctl_s3_reg;
            mag_s5_reg <= mag_s4_reg;
            ctl_s5_reg <= ctl_s4_reg;
            sum_s5_reg <= SUM_W'(sq_s4_reg[0]) + SUM_W'(sq_s4_reg[1]) + SUM_W'(sq_s4_reg[2]);
        end
    end

    // ---- square root, two radicand bits per stage
    logic              rt_vld_reg  [ROOT_W];
    ctl_t              rt_ctl_reg  [ROOT_W];
    mag3_t             rt_mag_reg  [ROOT_W];
    logic [REM_W-1:0]  rt_rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] rt_root_reg [ROOT_W];
    logic [SUM_W-1:0]  rt_sum_reg  [ROOT_W];

    genvar j;
    generate
        for (j = 0; j < ROOT_W; j++)
        begin : g_root
            logic              v_in;
            ctl_t              c_in;
            mag3_t             m_in;
            logic [REM_W-1:0]  rem_in;
            logic [ROOT_W-1:0] root_in;
            logic [SUM_W-1:0]  sum_in;
            logic [REM_W+1:0]  cur;
            logic [REM_W+1:0]  trial;
            logic [REM_W-1:0]  rem_next;
            logic [ROOT_W-1:0] root_next;

            if (j == 0)
            begin : g_first
                assign v_in    = vld_s5_reg;
                assign c_in    = ctl_s5_reg;
                assign m_in    = mag_s5_reg;
                assign rem_in  = '0;
                assign root_in = '0;
                assign sum_in  = sum_s5_reg;
            end
            else
            begin : g_chain
                assign v_in    = rt_vld_reg[j-1];
                assign c_in    = rt_ctl_reg[j-1];
                assign m_in    = rt_mag_reg[j-1];
                assign rem_in  = rt_rem_reg[j-1];
                assign root_in = rt_root_reg[j-1];
                assign sum_in  = rt_sum_reg[j-1];
            end

            always_comb
            begin
                cur   = {rem_in, sum_in[SUM_W-1-2*j -: 2]};
                trial = (REM_W+2)'({root_in, 2'b01});
                if (cur >= trial)
                begin
                    rem_next  = REM_W'(cur - trial);
                    root_next = {root_in[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = cur[REM_W-1:0];
                    root_next = {root_in[ROOT_W-2:0], 1'b0};
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    rt_vld_reg[j] <= 1'b0;
                end
                else if (adv)
                begin
                    rt_vld_reg[j] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rt_ctl_reg[j]  <= c_in;
                    rt_mag_reg[j]  <= m_in;
                    rt_rem_reg[j]  <= rem_next;
                    rt_root_reg[j] <= root_next;
                    rt_sum_reg[j]  <= sum_in;
                end
            end
        end
    endgenerate

    // ---- dividend set-up with rounding
    logic                     dp_vld_reg;
    ctl_t                     dp_ctl_reg;
    logic [2:0][DIVN_W-1:0]   dp_num_reg;
    logic [ROOT_W-1:0]        dp_len_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dp_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            dp_vld_reg <= rt_vld_reg[ROOT_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dp_ctl_reg <= rt_ctl_reg[ROOT_W-1];
            dp_len_reg <= rt_root_reg[ROOT_W-1];
            for (int i = 0; i < 3; i++)
            begin
                dp_num_reg[i] <= DIVN_W'({rt_mag_reg[ROOT_W-1][i], {FRAC_W{1'b0}}})
                               + DIVN_W'(rt_root_reg[ROOT_W-1] >> 1);
            end
        end
    end

    // ---- restoring division, one quotient bit per stage
    logic                    dv_vld_reg [Q_W];
    ctl_t                    dv_ctl_reg [Q_W];
    logic [2:0][DIVN_W-1:0]  dv_rem_reg [Q_W];
    logic [2:0][Q_W-1:0]     dv_q_reg   [Q_W];
    logic [ROOT_W-1:0]       dv_len_reg [Q_W];

    generate
        for (j = 0; j < Q_W; j++)
        begin : g_div
            localparam int B = Q_W - 1 - j;
            logic                   v_in;
            ctl_t                   c_in;
            logic [2:0][DIVN_W-1:0] r_in;
            logic [2:0][Q_W-1:0]    q_in;
            logic [ROOT_W-1:0]      l_in;
            logic [DIVN_W:0]        dvs;
            logic [2:0][DIVN_W-1:0] r_next;
            logic [2:0][Q_W-1:0]    q_next;

            if (j == 0)
            begin : g_first
                assign v_in = dp_vld_reg;
                assign c_in = dp_ctl_reg;
                assign r_in = dp_num_reg;
                assign q_in = '0;
                assign l_in = dp_len_reg;
            end
            else
            begin : g_chain
                assign v_in = dv_vld_reg[j-1];
                assign c_in = dv_ctl_reg[j-1];
                assign r_in = dv_rem_reg[j-1];
                assign q_in = dv_q_reg[j-1];
                assign l_in = dv_len_reg[j-1];
            end

            always_comb
            begin
                dvs = (DIVN_W+1)'(l_in) << B;
                for (int i = 0; i < 3; i++)
                begin
                    if ({1'b0, r_in[i]} >= dvs)
                    begin
                        r_next[i] = r_in[i] - dvs[DIVN_W-1:0];
                        q_next[i] = {q_in[i][Q_W-2:0], 1'b1};
                    end
                    else
                    begin
                        r_next[i] = r_in[i];
                        q_next[i] = {q_in[i][Q_W-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    dv_vld_reg[j] <= 1'b0;
                end
                else if (adv)
                begin
                    dv_vld_reg[j] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_ctl_reg[j] <= c_in;
                    dv_rem_reg[j] <= r_next;
                    dv_q_reg[j]   <= q_next;
                    dv_len_reg[j] <= l_in;
                end
            end
        end
    endgenerate

    // ---- sign restore; an all-zero vector stays zero
    logic signed [UNIT_W-1:0] res [3];
    logic                     out_vld_reg;
    unit_vec_t                out_vec_reg;
    logic [SIDE_W-1:0]        out_side_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (dv_ctl_reg[Q_W-1].zero)
            begin
                res[i] = '0;
            end
            else if (dv_ctl_reg[Q_W-1].neg[i])
            begin
                res[i] = -$signed({1'b0, dv_q_reg[Q_W-1][i]});
            end
            else
            begin
                res[i] = $signed({1'b0, dv_q_reg[Q_W-1][i]});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= dv_vld_reg[Q_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_vec_reg.x <= res[0];
            out_vec_reg.y <= res[1];
            out_vec_reg.z <= res[2];
            out_side_reg  <= dv_ctl_reg[Q_W-1].side;
        end
    end

    assign out_vld  = out_vld_reg;
    assign out_vec  = out_vec_reg;
    assign out_side = out_side_reg;

endmodule

`default_nettype wire

[hw/rtl/bqe_cross.sv]
// ----------------------------------------------------------------------------
// bqe_cross
// Two-stage cross product d x u of Q1.14 unit vectors.
// ----------------------------------------------------------------------------
`default_nettype none

module bqe_cross (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                adv,
    input  wire logic                in_vld,
    input  wire bqe_pkg::tag_t       in_tag,
    input  wire bqe_pkg::unit_vec_t  u,
    output logic                     out_vld,
    output bqe_pkg::wide_vec_t       cv,
    output bqe_pkg::tag_t            out_tag
);
    import bqe_pkg::*;

    logic signed [WIDE_W-1:0] prod [6];
    logic                     c1_vld_reg;
    logic signed [WIDE_W-1:0] c1_prod_reg [6];
    tag_t                     c1_tag_reg;
    logic                     c2_vld_reg;
    wide_vec_t                c2_cv_reg;
    tag_t                     c2_tag_reg;

    assign prod[0] = in_tag.vec.y * u.z;
    assign prod[1] = u.y * in_tag.vec.z;
    assign prod[2] = in_tag.vec.z * u.x;
    assign prod[3] = u.z * in_tag.vec.x;
    assign prod[4] = in_tag.vec.x * u.y;
    assign prod[5] = u.x * in_tag.vec.y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_vld_reg <= 1'b0;
            c2_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            c1_vld_reg <= in_vld;
            c2_vld_reg <= c1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_prod_reg      <= prod;
            c1_tag_reg.star  <= in_tag.star;
            c1_tag_reg.degen <= in_tag.degen;
            c1_tag_reg.vec   <= u;   // u travels on from here
            c2_cv_reg.x      <= c1_prod_reg[0] - c1_prod_reg[1];
            c2_cv_reg.y      <= c1_prod_reg[2] - c1_prod_reg[3];
            c2_cv_reg.z      <= c1_prod_reg[4] - c1_prod_reg[5];
            c2_tag_reg       <= c1_tag_reg;
        end
    end

    assign out_vld = c2_vld_reg;
    assign cv      = c2_cv_reg;
    assign out_tag = c2_tag_reg;

endmodule

`default_nettype wire

[hw/rtl/bqe_emit.sv]
// ----------------------------------------------------------------------------
// bqe_emit
// Corner offset scaling (two stages) and the quad serialiser that drives
// four vertices per star. Produces the pipeline advance.
// ----------------------------------------------------------------------------
`default_nettype none

`include "billboard_quad_expander_macros.svh"

module bqe_emit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_vld,
    input  wire bqe_pkg::tag_t               in_tag,
    input  wire bqe_pkg::unit_vec_t          w,
    input  wire logic [bqe_pkg::SIZE_W-1:0]  star_size,
    output logic                             adv,
    bqe_vert_if.source                       vert
);
    import bqe_pkg::*;

    // components 0..2 are u, 3..5 are w
    logic signed [UNIT_W-1:0] comp [6];
    logic [Q_W-1:0]           cmag [6];

    logic                     e1_vld_reg;
    logic [PROD_W-1:0]        e1_prod_reg [6];
    logic [5:0]               e1_neg_reg;
    star_t                    e1_star_reg;
    logic                     e1_degen_reg;

    logic [SCALE_W-1:0]       scaled [6];
    logic signed [OFF_W-1:0]  offm [6];
    logic signed [OFF_W-1:0]  off_next [6];

    logic                     e2_vld_reg;
    logic signed [OFF_W-1:0]  e2_off_reg [6];
    star_t                    e2_star_reg;
    logic                     e2_degen_reg;

    logic                     busy_reg;
    logic                     busy_next;
    logic [CORNER_W-1:0]      k_reg;
    logic [CORNER_W-1:0]      k_next;
    logic signed [OFF_W-1:0]  sv_off_reg [6];
    star_t                    sv_star_reg;
    logic                     sv_degen_reg;

    logic                     fire;
    logic                     load;

    assign comp[0] = in_tag.vec.x;
    assign comp[1] = in_tag.vec.y;
    assign comp[2] = in_tag.vec.z;
    assign comp[3] = w.x;
    assign comp[4] = w.y;
    assign comp[5] = w.z;

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            cmag[i] = comp[i][UNIT_W-1] ? Q_W'(-comp[i]) : Q_W'(comp[i]);
        end
    end

    // offset = round(|v| * 3 * size / 2^15), half away from zero
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            scaled[i] = (SCALE_W'(e1_prod_reg[i]) << 1) + SCALE_W'(e1_prod_reg[i])
                      + SCALE_W'(2 ** (ROUND_SH - 1));
            offm[i]   = $signed({1'b0, scaled[i][SCALE_W-1:ROUND_SH]});
            if (e1_degen_reg)
            begin
                off_next[i] = '0;
            end
            else
            begin
                off_next[i] = e1_neg_reg[i] ? -offm[i] : offm[i];
            end
        end
    end

    assign fire = busy_reg && vert.ready;
    assign load = e2_vld_reg && (!busy_reg || (fire && (k_reg == LAST_CORNER)));
    assign adv  = !e2_vld_reg || load;

    always_comb
    begin
        busy_next = busy_reg;
        k_next    = k_reg;
        if (load)
        begin
            busy_next = 1'b1;
            k_next    = '0;
        end
        else if (fire)
        begin
            if (k_reg == LAST_CORNER)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                k_next = k_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_vld_reg <= 1'b0;
            e2_vld_reg <= 1'b0;
            busy_reg   <= 1'b0;
            k_reg      <= '0;
        end
        else
        begin
            if (adv)
            begin
                e1_vld_reg <= in_vld;
                e2_vld_reg <= e1_vld_reg;
            end
            busy_reg <= busy_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 6; i++)
            begin
                e1_prod_reg[i] <= PROD_W'(cmag[i]) * PROD_W'(star_size);
                e1_neg_reg[i]  <= comp[i][UNIT_W-1];
            end
            e1_star_reg  <= in_tag.star;
            e1_degen_reg <= in_tag.degen;
            e2_off_reg   <= off_next;
            e2_star_reg  <= e1_star_reg;
            e2_degen_reg <= e1_degen_reg;
        end
        if (load)
        begin
            sv_off_reg   <= e2_off_reg;
            sv_star_reg  <= e2_star_reg;
            sv_degen_reg <= e2_degen_reg;
        end
    end

    // ---- corner arithmetic
    logic                     use_w;
    logic                     neg;
    logic signed [OFF_W-1:0]  off_x;
    logic signed [OFF_W-1:0]  off_y;
    logic signed [OFF_W-1:0]  off_z;
    logic signed [POS_W:0]    sum_x;
    logic signed [POS_W:0]    sum_y;
    logic signed [POS_W:0]    sum_z;

    assign use_w = CORNER_USE_W[k_reg];
    assign neg   = CORNER_NEG[k_reg];
    assign off_x = use_w ? sv_off_reg[3] : sv_off_reg[0];
    assign off_y = use_w ? sv_off_reg[4] : sv_off_reg[1];
    assign off_z = use_w ? sv_off_reg[5] : sv_off_reg[2];

    always_comb
    begin
        if (neg)
        begin
            sum_x = (POS_W+1)'(sv_star_reg.x) - (POS_W+1)'(off_x);
            sum_y = (POS_W+1)'(sv_star_reg.y) - (POS_W+1)'(off_y);
            sum_z = (POS_W+1)'(sv_star_reg.z) - (POS_W+1)'(off_z);
        end
        else
        begin
            sum_x = (POS_W+1)'(sv_star_reg.x) + (POS_W+1)'(off_x);
            sum_y = (POS_W+1)'(sv_star_reg.y) + (POS_W+1)'(off_y);
            sum_z = (POS_W+1)'(sv_star_reg.z) + (POS_W+1)'(off_z);
        end
    end

    assign vert.valid       = busy_reg;
    assign vert.vert_x      = sat_pos(sum_x);
    assign vert.vert_y      = sat_pos(sum_y);
    assign vert.vert_z      = sat_pos(sum_z);
    assign vert.tex_u       = CORNER_TEX_U[k_reg];
    assign vert.tex_v       = CORNER_TEX_V[k_reg];
    assign vert.vert_alpha  = sv_star_reg.alpha;
    assign vert.degenerate  = sv_degen_reg;
    assign vert.last_corner = (k_reg == LAST_CORNER);

    `BQE_ASSERT_IMPLIES(a_adv_when_empty, clk, rst_n, !e2_vld_reg, adv)
    `BQE_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, busy_reg && !vert.ready, busy_reg && $stable(k_reg))
    `BQE_ASSERT_NEXT(a_corner_step, clk, rst_n, fire && (k_reg != LAST_CORNER), busy_reg && (k_reg == $past(k_reg) + 2'd1))
    `BQE_ASSERT_NEXT(a_quad_done, clk, rst_n, fire && (k_reg == LAST_CORNER) && !e2_vld_reg, !busy_reg)

endmodule

`default_nettype wire

[hw/rtl/billboard_quad_expander.sv]
// ----------------------------------------------------------------------------
// billboard_quad_expander
// Expands each star into a camera-facing quad of four vertices.
// ----------------------------------------------------------------------------
// Usage:
//   star : one transaction per star (Q3.16 position, alpha byte).
//   vert : four transactions per star, corners p-w*h, p+u*h, p+w*h, p-u*h,
//          last_corner marks the fourth. degenerate flags a zero view z.
//   cfg  : star_size write, always ready; write only while the block is idle.
// Pipeline from star acceptance to the first vertex: three 53-stage
//   normalisers, each dominated by a 31-stage square root and a
//   15-stage divider, plus cross product and offset stages.
// Throughput: set by the single vertex channel, four vertices per star;
//   the pipeline itself takes a star every cycle until it backs up.
// A stalled vertex channel freezes the whole pipeline once a star waits
//   at its end; nothing is dropped or repeated and star.ready falls with it.
// Reset clears all valid bits and sets star_size to 197.
// ----------------------------------------------------------------------------
`default_nettype none

module billboard_quad_expander (
    input  wire logic  clk,
    input  wire logic  rst_n,
    bqe_star_if.sink   star,
    bqe_vert_if.source vert,
    bqe_cfg_if.sink    cfg
);
    import bqe_pkg::*;

    logic [SIZE_W-1:0] star_size_reg;
    logic              adv;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            star_size_reg <= SIZE_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            star_size_reg <= cfg.star_size;
        end
    end

    assign star.ready = adv;

    // ---- view direction
    star_t             star_in;
    wide_vec_t         nd;
    logic              v1_vld;
    unit_vec_t         d1;
    logic [STAR_W-1:0] side1;

    assign star_in.x     = star.pos_x;
    assign star_in.y     = star.pos_y;
    assign star_in.z     = star.pos_z;
    assign star_in.alpha = star.alpha_byte;
    assign nd.x = -WIDE_W'(star.pos_x);
    assign nd.y = -WIDE_W'(star.pos_y);
    assign nd.z = -WIDE_W'(star.pos_z);

    bqe_norm3 #(
        .SIDE_W (STAR_W)
    ) u_norm_view (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (star.valid),
        .in_vec   (nd),
        .in_side  (star_in),
        .out_vld  (v1_vld),
        .out_vec  (d1),
        .out_side (side1)
    );

    // ---- first side vector, (|dz|, |dz|, -sign(dz)*(dx+dy))
    logic signed [UNIT_W:0] dsum;
    wide_vec_t              uv;
    tag_t                   tag2;
    logic                   v2_vld;
    unit_vec_t              u2;
    logic [TAG_W-1:0]       side2;

    assign dsum = (UNIT_W+1)'(d1.x) + (UNIT_W+1)'(d1.y);

    always_comb
    begin
        uv.x = d1.z[UNIT_W-1] ? -WIDE_W'(d1.z) : WIDE_W'(d1.z);
        uv.y = uv.x;
        uv.z = d1.z[UNIT_W-1] ? WIDE_W'(dsum) : -WIDE_W'(dsum);
        tag2.star  = star_t'(side1);
        tag2.degen = (d1.z == '0);
        tag2.vec   = d1;
    end

    bqe_norm3 #(
        .SIDE_W (TAG_W)
    ) u_norm_side (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (v1_vld),
        .in_vec   (uv),
        .in_side  (tag2),
        .out_vld  (v2_vld),
        .out_vec  (u2),
        .out_side (side2)
    );

    // ---- second side vector
    logic             v3_vld;
    wide_vec_t        cv;
    tag_t             tag3;
    logic             v4_vld;
    unit_vec_t        w4;
    logic [TAG_W-1:0] side4;

    bqe_cross u_cross (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .in_vld  (v2_vld),
        .in_tag  (tag_t'(side2)),
        .u       (u2),
        .out_vld (v3_vld),
        .cv      (cv),
        .out_tag (tag3)
    );

    bqe_norm3 #(
        .SIDE_W (TAG_W)
    ) u_norm_up (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (v3_vld),
        .in_vec   (cv),
        .in_side  (tag3),
        .out_vld  (v4_vld),
        .out_vec  (w4),
        .out_side (side4)
    );

    bqe_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_vld    (v4_vld),
        .in_tag    (tag_t'(side4)),
        .w         (w4),
        .star_size (star_size_reg),
        .adv       (adv),
        .vert      (vert)
    );

endmodule

`default_nettype wire

[bench/bqe_quad_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqe_quad_checker
// Watches the star, vertex and size channels, works out the four corners of
// every accepted star and compares each vertex transaction with them in order.
// ----------------------------------------------------------------------------
module bqe_quad_checker (
    input  wire logic clk,
    input  wire logic rst_n,
    bqe_star_if       star,
    bqe_vert_if       vert,
    bqe_cfg_if        cfg,
    output int        errors,
    output int        pending
);
    import bqe_pkg::*;

    typedef struct packed {
        longint x;
        longint y;
        longint z;
    } lvec_t;

    typedef struct packed {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic                    tu;
        logic                    tv;
        logic [ALPHA_W-1:0]      alpha;
        logic                    degen;
        logic                    last;
    } corner_t;

    corner_t          corner_q[$];
    logic [SIZE_W-1:0] size_reg;

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic longint absl(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // unit vector in Q1.14, zero vector stays zero
    function automatic lvec_t unit_of(input lvec_t v);
        longint c[3];
        longint unsigned a[3];
        longint unsigned m;
        longint unsigned s;
        longint unsigned len;
        longint q;
        int sh;
        lvec_t r;
        c[0] = v.x;
        c[1] = v.y;
        c[2] = v.z;
        m = 0;
        s = 0;
        sh = 0;
        for (int i = 0; i < 3; i++)
        begin
            a[i] = absl(c[i]);
            if (a[i] > m)
                m = a[i];
        end
        if (m == 0)
            return '0;
        while (m < (64'd1 << 29))
        begin
            m = m << 1;
            sh++;
        end
        for (int i = 0; i < 3; i++)
        begin
            a[i] = a[i] << sh;
            s += a[i] * a[i];
        end
        len = int_sqrt(s);
        for (int i = 0; i < 3; i++)
        begin
            q = longint'(((a[i] << 14) + (len >> 1)) / len);
            c[i] = (c[i] < 0) ? -q : q;
        end
        r.x = c[0];
        r.y = c[1];
        r.z = c[2];
        return r;
    endfunction

    function automatic longint corner_offset(input longint v, input logic [SIZE_W-1:0] sz);
        longint unsigned n;
        longint q;
        n = longint'(absl(v)) * longint'(sz) * 3;
        q = longint'((n + (64'd1 << 14)) >> 15);
        return (v < 0) ? -q : q;
    endfunction

    function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
        if (v > 524287)
            v = 524287;
        if (v < -524288)
            v = -524288;
        return v[POS_W-1:0];
    endfunction

    task automatic expand_star(input longint px, input longint py, input longint pz,
                               input logic [ALPHA_W-1:0] a);
        lvec_t d;
        lvec_t uv;
        lvec_t u;
        lvec_t cv;
        lvec_t w;
        lvec_t ow;
        lvec_t ou;
        lvec_t off;
        longint sdz;
        longint sg;
        logic degen;
        corner_t c;
        uv = '{-px, -py, -pz};
        d = unit_of(uv);
        degen = (d.z == 0);
        ow = '0;
        ou = '0;
        if (!degen)
        begin
            sdz = (d.z < 0) ? -1 : 1;
            uv = '{d.z * sdz, d.z * sdz, -sdz * (d.x + d.y)};
            u = unit_of(uv);
            cv.x = d.y * u.z - u.y * d.z;
            cv.y = d.z * u.x - u.z * d.x;
            cv.z = d.x * u.y - u.x * d.y;
            w = unit_of(cv);
            ow = '{corner_offset(w.x, size_reg), corner_offset(w.y, size_reg),
                   corner_offset(w.z, size_reg)};
            ou = '{corner_offset(u.x, size_reg), corner_offset(u.y, size_reg),
                   corner_offset(u.z, size_reg)};
        end
        for (int k = 0; k < 4; k++)
        begin
            off = CORNER_USE_W[k] ? ow : ou;
            sg = CORNER_NEG[k] ? -1 : 1;
            c.x = clamp_pos(px + sg * off.x);
            c.y = clamp_pos(py + sg * off.y);
            c.z = clamp_pos(pz + sg * off.z);
            c.tu = CORNER_TEX_U[k];
            c.tv = CORNER_TEX_V[k];
            c.alpha = a;
            c.degen = degen;
            c.last = (k == LAST_CORNER);
            corner_q.push_back(c);
        end
    endtask

    assign pending = corner_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        corner_t e;
        corner_t g;
        if (!rst_n)
        begin
            size_reg <= SIZE_RESET;
            errors <= 0;
            corner_q.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                size_reg <= cfg.star_size;
            if (star.valid && star.ready)
                expand_star(longint'(star.pos_x), longint'(star.pos_y),
                            longint'(star.pos_z), star.alpha_byte);
            if (vert.valid && vert.ready)
            begin
                g = '{vert.vert_x, vert.vert_y, vert.vert_z, vert.tex_u, vert.tex_v,
                      vert.vert_alpha, vert.degenerate, vert.last_corner};
                if (corner_q.size() == 0)
                begin
                    $display("%0t: vertex transaction with nothing expected: %h", $time, g);
                    errors <= errors + 1;
                end
                else
                begin
                    e = corner_q.pop_front();
                    if (e !== g)
                    begin
                        $display("%0t: vertex mismatch exp x=%0d y=%0d z=%0d u=%b v=%b a=%0d dg=%b l=%b",
                                 $time, e.x, e.y, e.z, e.tu, e.tv, e.alpha, e.degen, e.last);
                        $display("%0t:                 got x=%0d y=%0d z=%0d u=%b v=%b a=%0d dg=%b l=%b",
                                 $time, g.x, g.y, g.z, g.tu, g.tv, g.alpha, g.degen, g.last);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end
endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives stars and star_size writes into the billboard quad expander with
// random gaps and vertex back-pressure; the checker judges every vertex.
// ----------------------------------------------------------------------------
module tb;
    import bqe_pkg::*;

    localparam int LIMIT = 400000;
    localparam int DRAIN = 200;

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   cycle_cnt = 0;
    int   ready_gap;
    logic burst;

    bqe_star_if star_ch ();
    bqe_vert_if vert_ch ();
    bqe_cfg_if  cfg_ch ();

    billboard_quad_expander u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .star  (star_ch),
        .vert  (vert_ch),
        .cfg   (cfg_ch)
    );

    bqe_quad_checker u_chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .star    (star_ch),
        .vert    (vert_ch),
        .cfg     (cfg_ch),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT)
        begin
            $display("FAIL billboard_quad_expander");
            $finish;
        end
    end

    // vertex back-pressure, with bursts of no stalling
    always @(posedge clk or negedge rst_n)
    begin
        int g;
        if (!rst_n)
        begin
            vert_ch.ready <= 1'b0;
            ready_gap <= 0;
            burst <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 63) == 0)
                burst <= ~burst;
            if (vert_ch.valid && vert_ch.ready)
            begin
                g = burst ? 0 : $urandom_range(0, 6);
                ready_gap <= g;
                vert_ch.ready <= (g == 0);
            end
            else if (ready_gap > 0)
            begin
                ready_gap <= ready_gap - 1;
                vert_ch.ready <= (ready_gap == 1);
            end
            else
                vert_ch.ready <= 1'b1;
        end
    end

    task automatic send_star(input logic signed [POS_W-1:0] x, input logic signed [POS_W-1:0] y,
                             input logic signed [POS_W-1:0] z, input logic [ALPHA_W-1:0] a);
        int g;
        g = burst ? 0 : $urandom_range(0, 6);
        if (g > 0)
        begin
            star_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        star_ch.valid <= 1'b1;
        star_ch.pos_x <= x;
        star_ch.pos_y <= y;
        star_ch.pos_z <= z;
        star_ch.alpha_byte <= a;
        @(posedge clk);
        while (!star_ch.ready)
            @(posedge clk);
    endtask

    function automatic logic signed [POS_W-1:0] pick_edge();
        case ($urandom_range(0, 4))
            0: return -524288;
            1: return 524287;
            2: return 0;
            3: return 1;
            default: return -1;
        endcase
    endfunction

    task automatic send_random_star();
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        int m;
        x = $urandom;
        y = $urandom;
        z = $urandom;
        m = $urandom_range(0, 9);
        if (m == 6)
            z = 0;
        else if (m == 7)
        begin
            x = $signed($urandom_range(0, 128)) - 64;
            y = $signed($urandom_range(0, 128)) - 64;
            z = $signed($urandom_range(0, 128)) - 64;
        end
        else if (m == 8)
        begin
            x = pick_edge();
            y = pick_edge();
            z = pick_edge();
        end
        else if (m == 9)
            z = $signed($urandom_range(0, 6)) - 3;
        send_star(x, y, z, $urandom);
    endtask

    // quiet the star channel and wait for every vertex before a size write
    task automatic write_size(input logic [SIZE_W-1:0] sz);
        star_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.star_size <= sz;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial
    begin
        logic [SIZE_W-1:0] sizes[6];
        rst_n = 1'b0;
        star_ch.valid <= 1'b0;
        star_ch.pos_x <= '0;
        star_ch.pos_y <= '0;
        star_ch.pos_z <= '0;
        star_ch.alpha_byte <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.star_size <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed stars at the reset size
        send_star(0, 0, 0, 8'h00);
        send_star(0, 0, 1, 8'hff);
        send_star(0, 0, -1, 8'haa);
        send_star(524287, 524287, 524287, 8'h55);
        send_star(-524288, -524288, -524288, 8'h01);
        send_star(-524288, 0, 0, 8'h80);
        send_star(0, 0, -524288, 8'h7f);
        send_star(0, 0, 524287, 8'h12);
        send_star(1, 1, 1, 8'h34);
        send_star(-1, -1, -1, 8'h56);
        send_star(524287, -524288, 1, 8'h78);
        send_star(123, 456, 0, 8'h9a);
        send_star(524287, 0, 1, 8'hbc);   // view z rounds to zero
        send_star(5, -7, -3, 8'hde);
        send_star(0, 524287, 524287, 8'hf0);
        send_star(-524288, 524287, -2, 8'h0f);
        send_star(1000, -1000, 200000, 8'hc3);
        repeat (40) send_random_star();

        sizes = '{16'd0, 16'hffff, 16'd1, 16'd30000, 16'(SIZE_RESET), 16'd0};
        sizes[5] = $urandom;
        foreach (sizes[i])
        begin
            write_size(sizes[i]);
            if (sizes[i] == 16'hffff)
            begin
                send_star(524287, 524287, 524287, 8'hff);
                send_star(-524288, -524288, 1, 8'h00);
            end
            repeat (60) send_random_star();
        end
        star_ch.valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (errors == 0)
            $display("PASS billboard_quad_expander");
        else
            $display("FAIL billboard_quad_expander");
        $finish;
    end
endmodule
